### rtl/ln_pkg.sv
// Shared constants and handshake types for the layer normalization unit.
package ln_pkg;

  localparam int FIELD_W       = 24;
  localparam int MAX_LEN_DEF   = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam int SD_EXTRA      = 6;
  localparam int Y_MAG_W       = 33;

  typedef struct packed {
    logic start;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

### rtl/ln_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ln_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/ln_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module ln_div
  import ln_pkg::*;
#(
  parameter int NW = 56,
  parameter int DW = 31
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  unit_ctl_t     ctl_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output unit_sts_t     sts_o,
  output logic [NW-1:0] quo_o
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem_q, rem_d, den_q;
  logic [NW-1:0] n_q, n_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [DW:0]   trial, diff;
  logic          ge;

  assign trial = {rem_q, n_q[NW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    n_d    = n_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      rem_d  = '0;
      n_d    = num_i;
      cnt_d  = CW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift one numerator bit in, subtract when it fits
      rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
      n_d   = {n_q[NW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    n_q   <= n_d;
    if (ctl_i.start) begin
      den_q <= den_i;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quo_o      = n_q;

endmodule

### rtl/ln_sqrt.sv
// Bit-serial integer square root, one root bit per cycle.
module ln_sqrt
  import ln_pkg::*;
#(
  parameter int IN_W  = 61,
  parameter int RES_W = 31
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  unit_ctl_t        ctl_i,
  input  logic [IN_W-1:0]  rad_i,
  output unit_sts_t        sts_o,
  output logic [RES_W-1:0] root_o
);

  localparam int RW = 2 * RES_W;
  localparam int CW = $clog2(RES_W + 1);

  logic [RW-1:0] v_q, v_d, res_q, res_d, bit_q, bit_d, trial;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;

  assign trial = res_q + bit_q;

  always_comb begin
    v_d    = v_q;
    res_d  = res_q;
    bit_d  = bit_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      v_d    = RW'(rad_i);
      res_d  = '0;
      bit_d  = RW'(1) << (RW - 2);
      cnt_d  = CW'(RES_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_d   = v_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign root_o     = res_q[RES_W-1:0];

endmodule

### rtl/layer_norm_unit.sv
// Layer normalization over one stored vector: top level with sequencer and datapath.
// Loading: one element per cycle while in_stall_o is low; the final request then runs
//   the mean division, the variance pass and division, the square root and, per element,
//   a division, multiply and rounding (DIV_NW = 56, SQ_RES_W = 34 at defaults), using
//   the one-bit-per-cycle shared divider and the bit-serial square root.
// Throughput: one vector at a time; in_stall_o stays high from the final request
//   until the last result is taken. Reset (rst_ni low, async) empties the vector.
module layer_norm_unit
  import ln_pkg::*;
#(
  parameter int MAX_LEN   = MAX_LEN_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [FIELD_W-1:0] sample_i,
  input  logic signed [FIELD_W-1:0] scale_i,
  input  logic signed [FIELD_W-1:0] shift_i,
  input  logic                      vector_end_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [FIELD_W-1:0] normalized_o,
  output logic                      result_last_o
);

  // Widths derived from the vector length and the fraction format
  localparam int IDX_W     = $clog2(MAX_LEN);
  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  localparam int SUM_W     = FIELD_W + CNT_W;
  localparam int MEAN_W    = FIELD_W + 1;
  localparam int MAG_W     = FIELD_W;
  localparam int ACC_W     = 2 * MAG_W + CNT_W;
  localparam int VE_W      = ACC_W + 1;
  localparam int SQ_IN_W   = VE_W + 2 * SD_EXTRA;
  localparam int SQ_RES_W  = (SQ_IN_W + 1) / 2;
  localparam int YN_W      = MAG_W + FRAC_BITS + SD_EXTRA + 1;
  localparam int NW_A      = (YN_W > ACC_W + 1) ? YN_W : ACC_W + 1;
  localparam int DIV_NW    = (NW_A > SUM_W) ? NW_A : SUM_W;
  localparam int DIV_DW    = (SQ_RES_W > CNT_W) ? SQ_RES_W : CNT_W;
  localparam int P_W       = Y_MAG_W + MAG_W;
  localparam int QM_W      = P_W + 1 - FRAC_BITS;
  localparam int RS_W      = P_W + 3 - FRAC_BITS;
  localparam int ENT_W     = 3 * FIELD_W;
  localparam longint unsigned EPS_Q =
    ((64'd1 << (2 * FRAC_BITS)) + 64'd50000) / 64'd100000;

  // Sequencer states
  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_MEAN  = 4'd1;
  localparam logic [3:0] S_MEANW = 4'd2;
  localparam logic [3:0] S_VRD   = 4'd3;
  localparam logic [3:0] S_VMUL  = 4'd4;
  localparam logic [3:0] S_VACC  = 4'd5;
  localparam logic [3:0] S_VDIV  = 4'd6;
  localparam logic [3:0] S_VDIVW = 4'd7;
  localparam logic [3:0] S_SQRT  = 4'd8;
  localparam logic [3:0] S_SQRTW = 4'd9;
  localparam logic [3:0] S_ERD   = 4'd10;
  localparam logic [3:0] S_EDIV  = 4'd11;
  localparam logic [3:0] S_EDIVW = 4'd12;
  localparam logic [3:0] S_EMUL  = 4'd13;
  localparam logic [3:0] S_ERND  = 4'd14;
  localparam logic [3:0] S_EOUT  = 4'd15;

  logic [3:0]               state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic [ACC_W-1:0]         acc_q, acc_d;
  logic signed [MEAN_W-1:0] mean_q, mean_d;
  logic [ACC_W-1:0]         var_q, var_d;
  logic [SQ_RES_W-1:0]      sd_q, sd_d;
  logic [Y_MAG_W-1:0]       ymag_q, ymag_d;
  logic                     neg_q, neg_d;
  logic signed [FIELD_W-1:0] shf_q, shf_d;
  logic [MAG_W-1:0]         smag_q, smag_d;
  logic [P_W-1:0]           prod_q;
  logic [Y_MAG_W-1:0]       mul_a;
  logic [MAG_W-1:0]         mul_b;
  logic                     out_valid_q, out_valid_d, last_q, last_d;
  logic signed [FIELD_W-1:0] res_q, res_d;

  logic                     in_acc, out_acc, is_last;
  logic [ENT_W-1:0]         rd_data;
  logic signed [FIELD_W-1:0] rd_sample, rd_scale, rd_shift;
  logic signed [MEAN_W-1:0] d_val;
  logic [MAG_W-1:0]         d_mag;
  logic [SUM_W-1:0]         sum_mag;

  unit_ctl_t                div_ctl, sq_ctl;
  unit_sts_t                div_sts, sq_sts;
  logic [DIV_NW-1:0]        div_num, div_quo;
  logic [DIV_DW-1:0]        div_den;
  logic [SQ_IN_W-1:0]       sq_rad;
  logic [SQ_RES_W-1:0]      sq_root;

  logic [QM_W-1:0]          q_mag;
  logic [P_W:0]             p_rnd;
  logic signed [RS_W-1:0]   r_val;

  assign in_stall_o    = state_q != S_LOAD;
  assign in_acc        = in_valid_i && !in_stall_o;
  assign out_acc       = out_valid_q && !out_stall_i;
  assign is_last       = (CNT_W'(idx_q) + 1'b1) == cnt_q;
  assign out_valid_o   = out_valid_q;
  assign normalized_o  = res_q;
  assign result_last_o = last_q;

  // Vector store: sample, scale and shift side by side
  ln_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_LEN)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (in_acc),
    .waddr_i(cnt_q[IDX_W-1:0]),
    .wdata_i({sample_i, scale_i, shift_i}),
    .raddr_i(idx_q),
    .rdata_o(rd_data)
  );

  assign rd_sample = rd_data[ENT_W-1 -: FIELD_W];
  assign rd_scale  = rd_data[2*FIELD_W-1 -: FIELD_W];
  assign rd_shift  = rd_data[FIELD_W-1:0];

  // Deviation from the mean is exact in MEAN_W bits
  assign d_val = {rd_sample[FIELD_W-1], rd_sample} - mean_q;
  assign d_mag = d_val[MEAN_W-1] ? MAG_W'(-d_val) : MAG_W'(d_val);
  assign sum_mag = sum_q[SUM_W-1] ? -sum_q : sum_q;

  // Shared divider: mean, variance and every normalized element
  ln_div #(
    .NW(DIV_NW),
    .DW(DIV_DW)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (div_ctl),
    .num_i (div_num),
    .den_i (div_den),
    .sts_o (div_sts),
    .quo_o (div_quo)
  );

  ln_sqrt #(
    .IN_W (SQ_IN_W),
    .RES_W(SQ_RES_W)
  ) u_sqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (sq_ctl),
    .rad_i (sq_rad),
    .sts_o (sq_sts),
    .root_o(sq_root)
  );

  // Radicand: (variance + epsilon) with 12 extra fraction bits
  assign sq_rad = SQ_IN_W'({1'b0, var_q} + VE_W'(EPS_Q)) << (2 * SD_EXTRA);

  always_comb begin
    div_num = '0;
    div_den = '0;
    case (state_q)
      S_MEAN: begin
        div_num = DIV_NW'(sum_mag) + DIV_NW'(cnt_q >> 1);
        div_den = DIV_DW'(cnt_q);
      end
      S_VDIV: begin
        div_num = DIV_NW'(acc_q) + DIV_NW'(cnt_q >> 1);
        div_den = DIV_DW'(cnt_q);
      end
      S_EDIV: begin
        div_num = DIV_NW'({d_mag, {(FRAC_BITS + SD_EXTRA){1'b0}}}) + DIV_NW'(sd_q >> 1);
        div_den = DIV_DW'(sd_q);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  assign div_ctl.start = (state_q == S_MEAN) || (state_q == S_VDIV) || (state_q == S_EDIV);
  assign sq_ctl.start  = state_q == S_SQRT;

  // Shared multiplier: squares in the variance pass, gain in the emit pass
  assign mul_a = (state_q == S_EMUL) ? ymag_q : Y_MAG_W'(d_mag);
  assign mul_b = (state_q == S_EMUL) ? smag_q : d_mag;

  always_ff @(posedge clk_i) begin
    prod_q <= P_W'(mul_a) * P_W'(mul_b);
  end

  // Round the product by FRAC_BITS, ties away from zero, then add the offset
  assign p_rnd = {1'b0, prod_q} + ((P_W + 1)'(1) << (FRAC_BITS - 1));
  assign q_mag = p_rnd[P_W:FRAC_BITS];
  assign r_val = (neg_q ? -$signed(RS_W'(q_mag)) : $signed(RS_W'(q_mag)))
                 + RS_W'(shf_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    idx_d       = idx_q;
    acc_d       = acc_q;
    mean_d      = mean_q;
    var_d       = var_q;
    sd_d        = sd_q;
    ymag_d      = ymag_q;
    neg_d       = neg_q;
    shf_d       = shf_q;
    smag_d      = smag_q;
    out_valid_d = out_valid_q;
    last_d      = last_q;
    res_d       = res_q;
    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          cnt_d = cnt_q + 1'b1;
          sum_d = sum_q + SUM_W'(sample_i);
          if (vector_end_i || (cnt_d == CNT_W'(MAX_LEN))) begin
            state_d = S_MEAN;
          end
        end
      end
      S_MEAN: state_d = S_MEANW;
      S_MEANW: begin
        if (div_sts.done) begin
          mean_d  = sum_q[SUM_W-1] ? -$signed({1'b0, div_quo[MEAN_W-2:0]})
                                   : $signed({1'b0, div_quo[MEAN_W-2:0]});
          idx_d   = '0;
          acc_d   = '0;
          state_d = S_VRD;
        end
      end
      S_VRD:  state_d = S_VMUL;
      S_VMUL: state_d = S_VACC;
      S_VACC: begin
        acc_d = acc_q + ACC_W'(prod_q);
        if (is_last) begin
          state_d = S_VDIV;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_VRD;
        end
      end
      S_VDIV: state_d = S_VDIVW;
      S_VDIVW: begin
        if (div_sts.done) begin
          var_d   = div_quo[ACC_W-1:0];
          state_d = S_SQRT;
        end
      end
      S_SQRT: state_d = S_SQRTW;
      S_SQRTW: begin
        if (sq_sts.done) begin
          sd_d    = (sq_root == '0) ? SQ_RES_W'(1) : sq_root;
          idx_d   = '0;
          state_d = S_ERD;
        end
      end
      S_ERD: state_d = S_EDIV;
      S_EDIV: begin
        // hold what the rest of this element needs
        neg_d   = d_val[MEAN_W-1] ^ rd_scale[FIELD_W-1];
        smag_d  = rd_scale[FIELD_W-1] ? MAG_W'(-rd_scale) : MAG_W'(rd_scale);
        shf_d   = rd_shift;
        state_d = S_EDIVW;
      end
      S_EDIVW: begin
        if (div_sts.done) begin
          ymag_d  = div_quo[Y_MAG_W-1:0];
          state_d = S_EMUL;
        end
      end
      S_EMUL: state_d = S_ERND;
      S_ERND: begin
        if (r_val > RS_W'(8388607)) begin
          res_d = FIELD_W'(8388607);
        end else if (r_val < -RS_W'(8388608)) begin
          res_d = FIELD_W'(-8388608);
        end else begin
          res_d = r_val[FIELD_W-1:0];
        end
        last_d      = is_last;
        out_valid_d = 1'b1;
        state_d     = S_EOUT;
      end
      S_EOUT: begin
        if (out_acc) begin
          out_valid_d = 1'b0;
          if (is_last) begin
            cnt_d   = '0;
            sum_d   = '0;
            state_d = S_LOAD;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_ERD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      sum_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    mean_q <= mean_d;
    var_q  <= var_d;
    sd_q   <= sd_d;
    ymag_q <= ymag_d;
    neg_q  <= neg_d;
    shf_q  <= shf_d;
    smag_q <= smag_d;
    last_q <= last_d;
    res_q  <= res_d;
  end

  // The vector empties once its last result is taken
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && result_last_o) |=> (cnt_q == '0))
    else $error("vector not emptied after last result");

  // No new request while the shared divider is at work
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !div_sts.busy)
    else $error("request accepted during division");

  // Fill count never passes the store depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_LEN))
    else $error("element count beyond store depth");

  // Divisor of the emit pass is never zero
  a_sd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EDIV) |-> (sd_q != '0))
    else $error("zero standard deviation in emit pass");

endmodule
